// ===== rtl/core/soft_text_stream_compare_defines.svh =====
// assertion macros for the stream compare block
// the enclosing module provides clk and arst_n
`ifndef SOFT_TEXT_STREAM_COMPARE_DEFINES_SVH
`define SOFT_TEXT_STREAM_COMPARE_DEFINES_SVH

`ifndef SYNTHESIS
`define STC_ASSERT(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("stc assertion failed");
`define STC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stc assertion failed");
`else
`define STC_ASSERT(name, cond)
`define STC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== rtl/core/stc_pkg.sv =====
`default_nettype none

package stc_pkg;

	// default token queue depth
	localparam int QUEUE_DEPTH_DEF = 16;

	// command queue between front and back
	localparam int CMD_FIFO_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_FIFO_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

	// token encoding: bytes 0..255, end of line 256
	localparam int TOK_W = 9;
	localparam logic [TOK_W-1:0] TOK_EOL = 9'h100;

	localparam logic [7:0] BYTE_SP = 8'h20;
	localparam logic [7:0] BYTE_TAB = 8'h09;
	localparam logic [7:0] BYTE_CR = 8'h0d;
	localparam logic [7:0] BYTE_LF = 8'h0a;

	typedef enum logic [1:0] {
		OP_DATA = 2'd0,
		OP_END = 2'd1,
		OP_START = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		VERDICT_DIFF = 2'd0,
		VERDICT_EQUIV = 2'd1,
		VERDICT_OVERFLOW = 2'd2
	} verdict_t;

	typedef enum logic [1:0] {
		REG_IGNORE_EOL = 2'd0,
		REG_IGNORE_SP = 2'd1,
		REG_TAB_AS_SP = 2'd2
	} reg_idx_t;

	// one step of work for the back end
	typedef struct packed {
		logic start;
		logic side;
		logic has_tok;
		logic [TOK_W-1:0] tok;
		logic fin;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic ignore_eol;
		logic ignore_sp;
		logic tab_as_sp;
	} cfg_t;

	// back end status toward the top level
	typedef struct packed {
		logic verdict_given;
		logic start_fire;
	} back_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/soft_text_stream_compare.sv =====
// channel   direction  handshake              word
// cfg       in         psel/penable/pwrite    paddr, pwdata (prdata on read)
// in        in         in_valid/in_ready      op, side, data_byte
// out       out        out_valid/out_ready    verdict
//
// one input word per cycle while the queue has room; a data byte that releases
// a held cr and makes a token of its own issues two commands, and the next word
// waits until the second is pushed. the back takes one command per cycle while
// no verdict waits; a verdict is registered after its command leaves the queue.
// asynchronous active-low reset clears all control state; no clearing pass.
// a waiting verdict stalls the back; the front stalls once the queue is full.
`default_nettype none

`include "soft_text_stream_compare_defines.svh"

module soft_text_stream_compare
	import stc_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] op,
	input wire logic side,
	input wire logic [7:0] data_byte,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] verdict
);

	cfg_t cfg_q;
	logic cfg_wr;
	logic fifo_full;
	logic fifo_push;
	cmd_t fifo_in;
	logic fifo_valid;
	cmd_t fifo_out;
	logic fifo_pop;
	back_stat_t bstat;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_IGNORE_EOL: cfg_q.ignore_eol <= pwdata[0];
				REG_IGNORE_SP: cfg_q.ignore_sp <= pwdata[0];
				REG_TAB_AS_SP: cfg_q.tab_as_sp <= pwdata[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_IGNORE_EOL: prdata = {31'd0, cfg_q.ignore_eol};
			REG_IGNORE_SP: prdata = {31'd0, cfg_q.ignore_sp};
			REG_TAB_AS_SP: prdata = {31'd0, cfg_q.tab_as_sp};
			default: prdata = '0;
		endcase
	end

	stc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.side(side),
		.data_byte(data_byte),
		.fifo_full(fifo_full),
		.push(fifo_push),
		.push_cmd(fifo_in)
	);

	stc_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(fifo_push),
		.push_cmd(fifo_in),
		.full(fifo_full),
		.valid(fifo_valid),
		.cmd(fifo_out),
		.pop(fifo_pop)
	);

	stc_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(fifo_valid),
		.cmd(fifo_out),
		.cmd_pop(fifo_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.verdict(verdict),
		.stat(bstat)
	);

	// checks
	`STC_ASSERT(a_out_needs_verdict, !out_valid || bstat.verdict_given)
	`STC_ASSERT(a_verdict_code, !out_valid || verdict != 2'd3)
	`STC_ASSERT(a_fifo_room, !(fifo_push && fifo_full && !fifo_pop))
	`STC_ASSERT_NEXT(a_given_sticky, bstat.verdict_given && !bstat.start_fire, bstat.verdict_given)

endmodule

`default_nettype wire

// ===== rtl/core/stc_front.sv =====
`default_nettype none

module stc_front
	import stc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] op,
	input wire logic side,
	input wire logic [7:0] data_byte,
	input wire logic fifo_full,
	output logic push,
	output cmd_t push_cmd
);

	logic [1:0] pend_q;
	logic [1:0] ended_q;
	logic extra_valid_q;
	cmd_t extra_q;

	logic accept;
	logic pend;
	logic merge;
	logic drop;
	logic hold;
	logic byte_tok;
	logic [TOK_W-1:0] tok_b;
	cmd_t cmd_a;
	cmd_t cmd_b;
	logic has_a;
	logic has_b;

	assign in_ready = !extra_valid_q && !fifo_full;
	assign accept = in_valid && in_ready;

	// byte classification
	assign pend = pend_q[side];
	assign merge = pend && cfg.ignore_eol && (data_byte == BYTE_LF);
	assign drop = cfg.ignore_sp &&
		((data_byte == BYTE_SP) || (cfg.tab_as_sp && (data_byte == BYTE_TAB)));
	assign hold = cfg.ignore_eol && (data_byte == BYTE_CR);
	assign byte_tok = !merge && !drop && !hold;
	assign tok_b = (cfg.ignore_eol && (data_byte == BYTE_LF)) ? TOK_EOL : {1'b0, data_byte};

	// commands for the accepted word
	always_comb begin
		cmd_a = '0;
		cmd_b = '0;
		has_a = 1'b0;
		has_b = 1'b0;
		cmd_a.side = side;
		cmd_b.side = side;
		case (op_t'(op))
			OP_START: begin
				cmd_a.start = 1'b1;
				cmd_a.last = 1'b1;
				has_a = 1'b1;
			end
			OP_DATA: begin
				if (!ended_q[side]) begin
					if (pend) begin
						cmd_a.has_tok = 1'b1;
						cmd_a.tok = TOK_EOL;
						cmd_a.last = !byte_tok;
						has_a = 1'b1;
						cmd_b.has_tok = 1'b1;
						cmd_b.tok = tok_b;
						cmd_b.last = 1'b1;
						has_b = byte_tok;
					end else begin
						cmd_a.has_tok = 1'b1;
						cmd_a.tok = tok_b;
						cmd_a.last = 1'b1;
						has_a = byte_tok;
					end
				end
			end
			OP_END: begin
				if (!ended_q[side]) begin
					cmd_a.has_tok = pend;
					cmd_a.tok = TOK_EOL;
					cmd_a.fin = 1'b1;
					cmd_a.last = 1'b1;
					has_a = 1'b1;
				end
			end
			default: begin
				has_a = 1'b0;
			end
		endcase
	end

	// push source: held second command first
	always_comb begin
		if (extra_valid_q) begin
			push = !fifo_full;
			push_cmd = extra_q;
		end else begin
			push = accept && has_a;
			push_cmd = cmd_a;
		end
	end

	// pending cr and ended flags per side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			ended_q <= '0;
			extra_valid_q <= 1'b0;
		end else begin
			if (extra_valid_q && !fifo_full) begin
				extra_valid_q <= 1'b0;
			end
			if (accept) begin
				case (op_t'(op))
					OP_START: begin
						pend_q <= '0;
						ended_q <= '0;
					end
					OP_DATA: begin
						if (!ended_q[side]) begin
							pend_q[side] <= hold;
							extra_valid_q <= has_b;
						end
					end
					OP_END: begin
						if (!ended_q[side]) begin
							pend_q[side] <= 1'b0;
							ended_q[side] <= 1'b1;
						end
					end
					default: begin
						pend_q <= pend_q;
					end
				endcase
			end
		end
	end

	// second command payload
	always_ff @(posedge clk) begin
		if (accept) begin
			extra_q <= cmd_b;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/stc_cmd_fifo.sv =====
`default_nettype none

module stc_cmd_fifo
	import stc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire cmd_t push_cmd,
	output logic full,
	output logic valid,
	output cmd_t cmd,
	input wire logic pop
);

	cmd_t buf_q [CMD_FIFO_DEPTH];
	logic [CMD_PTR_W-1:0] wr_q;
	logic [CMD_PTR_W-1:0] rd_q;
	logic [CMD_CNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CMD_CNT_W'(CMD_FIFO_DEPTH));
	assign valid = (cnt_q != '0);
	assign cmd = buf_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/stc_back.sv =====
`default_nettype none

module stc_back
	import stc_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire cmd_t cmd,
	output logic cmd_pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] verdict,
	output back_stat_t stat
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// one token queue serves whichever side is ahead; the other side is then empty
	logic [TOK_W-1:0] mem [QUEUE_DEPTH];
	logic [CW-1:0] cnt_q;
	logic own_q;
	logic [AW-1:0] rd_q;
	logic [AW-1:0] wr_q;
	logic [TOK_W-1:0] head_q;
	logic [1:0] ended_q;
	logic given_q;
	logic out_valid_q;
	logic [1:0] verdict_q;

	logic fire;
	logic act;
	logic is_start;
	logic other_has;
	logic qfull;
	logic do_pop;
	logic do_push;
	logic mismatch;
	logic overflow;
	logic [CW-1:0] cnt_n;
	logic own_n;
	logic [1:0] ended_n;
	logic nz0;
	logic nz1;
	logic done0;
	logic done1;
	logic eq;
	logic diff2;
	logic emit;
	verdict_t code;
	logic [AW-1:0] rd_n;
	logic [AW-1:0] rd_inc;
	logic [AW-1:0] wr_inc;

	assign rd_inc = (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
	assign wr_inc = (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;

	// command issue, held while a verdict waits
	assign fire = cmd_valid && (!out_valid_q || out_ready);
	assign cmd_pop = fire;
	assign is_start = fire && cmd.start;
	assign act = fire && !cmd.start && !given_q;

	// token against the other side's head, or into own queue
	assign other_has = (cnt_q != '0) && (own_q != cmd.side);
	assign qfull = (cnt_q == CW'(QUEUE_DEPTH));
	assign do_pop = act && cmd.has_tok && other_has;
	assign do_push = act && cmd.has_tok && !other_has && !qfull;
	assign mismatch = do_pop && (head_q != cmd.tok);
	assign overflow = act && cmd.has_tok && !other_has && qfull;

	always_comb begin
		if (do_pop) begin
			cnt_n = cnt_q - 1'b1;
		end else if (do_push) begin
			cnt_n = cnt_q + 1'b1;
		end else begin
			cnt_n = cnt_q;
		end
	end
	assign own_n = do_push ? cmd.side : own_q;

	// end-of-comparison check on the state after this command
	always_comb begin
		ended_n = ended_q;
		if (act && cmd.fin) begin
			ended_n[cmd.side] = 1'b1;
		end
	end
	assign nz0 = (cnt_n != '0) && !own_n;
	assign nz1 = (cnt_n != '0) && own_n;
	assign done0 = ended_n[0] && !nz0;
	assign done1 = ended_n[1] && !nz1;
	assign eq = done0 && done1;
	assign diff2 = (done0 && nz1) || (done1 && nz0);
	assign emit = act && (mismatch || overflow || (cmd.last && (eq || diff2)));

	always_comb begin
		if (mismatch) begin
			code = VERDICT_DIFF;
		end else if (overflow) begin
			code = VERDICT_OVERFLOW;
		end else if (eq) begin
			code = VERDICT_EQUIV;
		end else begin
			code = VERDICT_DIFF;
		end
	end

	always_comb begin
		if (is_start) begin
			rd_n = '0;
		end else if (do_pop) begin
			rd_n = rd_inc;
		end else begin
			rd_n = rd_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			own_q <= 1'b0;
			rd_q <= '0;
			wr_q <= '0;
			ended_q <= '0;
			given_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_q <= rd_n;
			if (is_start) begin
				cnt_q <= '0;
				own_q <= 1'b0;
				wr_q <= '0;
				ended_q <= '0;
				given_q <= 1'b0;
			end else begin
				cnt_q <= cnt_n;
				own_q <= own_n;
				ended_q <= ended_n;
				if (do_push) begin
					wr_q <= wr_inc;
				end
				if (emit) begin
					given_q <= 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// token memory with registered head read and write bypass
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= cmd.tok;
		end
		if (do_push && (wr_q == rd_n)) begin
			head_q <= cmd.tok;
		end else begin
			head_q <= mem[rd_n];
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (emit) begin
			verdict_q <= code;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict = verdict_q;
	assign stat.verdict_given = given_q;
	assign stat.start_fire = is_start;

endmodule

`default_nettype wire
